// ===== hw/rtl/dmp_pkg.sv =====
// dmp_pkg: shared types, codes and reset constants for the button debounce block.
// No dependencies; used by every other file of the block but dmp_out_if.
`default_nettype none

package dmp_pkg;

  localparam int TIME_BITS_DEF = 32;  // default width of the internal time base
  localparam int NOW_W         = 32;  // width of the now_ms field
  localparam int CFG_W         = 16;  // widest configuration register
  localparam int CFG_IDX_W     = 2;   // four registers

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_GAP      = 2'd1,
    CFG_WINDOW   = 2'd2,
    CFG_RAPID    = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] GAP_RST      = 16'd500;
  localparam logic [15:0] WINDOW_RST   = 16'd1500;
  localparam logic [7:0]  RAPID_RST    = 8'd3;

  // Contact phase
  typedef enum logic [1:0] {
    PH_OPEN     = 2'd0,
    PH_CONTACT  = 2'd1,
    PH_PRESSING = 2'd2
  } phase_t;

  // Result codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_CONTACT  = 3'd1,
    EV_PRESSING = 3'd2,
    EV_PRESS    = 3'd3,
    EV_RAPID    = 3'd4
  } event_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] gap_limit_ms;
    logic [15:0] window_ms;
    logic [7:0]  rapid_count;
  } cfg_t;

  typedef struct packed {
    event_t event_code;
    logic   busy_res;
  } res_t;

  typedef struct packed {
    phase_t phase;
    logic   tracking;
  } core_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dmp_in_if.sv =====
// dmp_in_if: poll channel (button level and millisecond time) with valid/ready.
// Depends on dmp_pkg for the time field width.
`default_nettype none

interface dmp_in_if;
  logic                     valid;
  logic                     ready;
  logic                     button_level;
  logic [dmp_pkg::NOW_W-1:0] now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dmp_out_if.sv =====
// dmp_out_if: result channel (event code and busy flag) with valid/ready.
// No dependencies.
`default_nettype none

interface dmp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic       busy_res;

  modport source (output valid, output event_code, output busy_res, input ready);
  modport sink   (input valid, input event_code, input busy_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dmp_cfg.sv =====
// dmp_cfg: configuration register file, written through a plain write port.
// Depends on dmp_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module dmp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmp_pkg::CFG_W-1:0]     cfg_data,
  output dmp_pkg::cfg_t                 cfg
);
  import dmp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= DEBOUNCE_RST;
      cfg.gap_limit_ms <= GAP_RST;
      cfg.window_ms    <= WINDOW_RST;
      cfg.rapid_count  <= RAPID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg.debounce_ms  <= cfg_data;
        CFG_GAP:      cfg.gap_limit_ms <= cfg_data;
        CFG_WINDOW:   cfg.window_ms    <= cfg_data;
        CFG_RAPID:    cfg.rapid_count  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dmp_core.sv =====
// dmp_core: debounce / press-series state and the single-pass update for one poll.
// Depends on dmp_pkg (phase and event codes, cfg_t, res_t, core_status_t).
`default_nettype none

module dmp_core #(
  parameter int TIME_BITS = dmp_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 level,
  input  logic [TIME_BITS-1:0] now,
  input  dmp_pkg::cfg_t        cfg,
  output dmp_pkg::res_t        res,
  output dmp_pkg::core_status_t status
);
  import dmp_pkg::*;

  typedef logic [TIME_BITS-1:0] tstamp_t;

  phase_t     phase, phase_next;
  tstamp_t    deadline, deadline_next;
  tstamp_t    first_time, first_next;
  tstamp_t    last_time, last_next;
  logic [7:0] press_count, count_next;
  logic       tracking, tracking_next;

  tstamp_t    first_m, last_m, dl_diff, since_first, since_last;
  logic [7:0] count_m;
  logic       gap_over, win_over, rapid_hit, clear;
  event_t     ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OPEN;
      deadline    <= '0;
      first_time  <= '0;
      last_time   <= '0;
      press_count <= '0;
      tracking    <= 1'b1;
    end else if (step) begin
      phase       <= phase_next;
      deadline    <= deadline_next;
      first_time  <= first_next;
      last_time   <= last_next;
      press_count <= count_next;
      tracking    <= tracking_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    deadline_next = deadline;
    first_m       = first_time;
    last_m        = last_time;
    count_m       = press_count;
    tracking_next = tracking;
    clear         = 1'b0;
    dl_diff       = now - deadline;   // wrap-safe: reached when top bit clear

    // contact phase
    if (level) begin
      phase_next = PH_OPEN;
    end else begin
      case (phase)
        PH_OPEN: begin
          phase_next    = PH_CONTACT;
          deadline_next = now + TIME_BITS'(cfg.debounce_ms);
        end
        PH_CONTACT: begin
          if (!dl_diff[TIME_BITS-1]) begin
            if (press_count == 8'd0) first_m = now;
            else                     last_m  = now;
            if (press_count != 8'hFF) count_m = press_count + 8'd1;
            phase_next = PH_PRESSING;
          end
        end
        default: ;  // pressing holds
      endcase
    end

    // elapsed times, zero stamp means none
    since_first = (first_m == '0) ? '0 : now - first_m;
    since_last  = (last_m == '0) ? since_first : now - last_m;
    gap_over    = since_last > TIME_BITS'(cfg.gap_limit_ms);
    win_over    = since_first > TIME_BITS'(cfg.window_ms);
    rapid_hit   = (count_m == cfg.rapid_count) && !win_over;

    if (level) begin
      ev = EV_NONE;
      if (tracking && (gap_over || win_over)) begin
        ev    = EV_PRESS;
        clear = 1'b1;
      end
      tracking_next = 1'b1;
    end else begin
      ev = (phase_next == PH_CONTACT) ? EV_CONTACT : EV_PRESSING;
      if (tracking) begin
        if (rapid_hit) begin
          ev            = EV_RAPID;
          clear         = 1'b1;
          tracking_next = 1'b0;
        end else if (gap_over || win_over) begin
          ev            = EV_PRESS;
          clear         = 1'b1;
          tracking_next = 1'b0;
        end
      end
    end

    first_next = clear ? '0 : first_m;
    last_next  = clear ? '0 : last_m;
    count_next = clear ? 8'd0 : count_m;

    res.event_code = ev;
    res.busy_res   = tracking_next && !((phase_next == PH_OPEN) && (count_next == 8'd0));
  end

  assign status.phase    = phase;
  assign status.tracking = tracking;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_multi_press.sv =====
// button_debounce_multi_press: top level; poll input register, core, result register.
// Depends on dmp_pkg, dmp_in_if, dmp_out_if, dmp_cfg and dmp_core.
//
//   channel   dir   transaction payload                 handshake
//   poll      in    button_level (1), now_ms (32)       poll.valid / poll.ready
//   result    out   event_code (3), busy_res (1)        result.valid / result.ready
//   cfg       in    cfg_index (2), cfg_data (16)        cfg_we, no back-pressure
//
// One poll per clock sustained while the result side accepts; each poll yields exactly
// one result, through the input register, then the result register.
// The whole update is one pass of subtract/compare logic on the core state.
// A stalled result holds the result register; the input register still takes one
// more poll, then poll.ready drops until the result side moves again.
// Synchronous active-high reset restores the register defaults and an open,
// tracking, empty press series; no clearing pass.
`default_nettype none

module button_debounce_multi_press #(
  parameter int TIME_BITS = dmp_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dmp_in_if.sink                        poll,
  dmp_out_if.source                     result,
  input  logic                          cfg_we,
  input  logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmp_pkg::CFG_W-1:0]     cfg_data
);
  import dmp_pkg::*;

  cfg_t         cfg;
  res_t         core_res;
  core_status_t core_st;

  // input register
  logic             s1_valid;
  logic             s1_level;
  logic [NOW_W-1:0] s1_now;

  // result register
  logic out_valid;
  res_t out_res;

  logic advance, step;

  assign advance    = !out_valid || result.ready;
  assign step       = s1_valid && advance;   // poll in s1 is applied to the state
  assign poll.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_level <= poll.button_level;
      s1_now   <= poll.now_ms;
    end
  end

  dmp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // time taken modulo 2^TIME_BITS (zero-extended when wider than the field)
  dmp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .level  (s1_level),
    .now    (TIME_BITS'(s1_now)),
    .cfg    (cfg),
    .res    (core_res),
    .status (core_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= core_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.event_code = out_res.event_code;
  assign result.busy_res   = out_res.busy_res;

  // a reported press or rapid press always ends the tracked series
  a_press_not_busy: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.event_code == EV_PRESS || result.event_code == EV_RAPID))
      |-> !result.busy_res)
    else $error("press reported while series still busy");

  // rapid press stops tracking until the next release
  a_rapid_stops_tracking: assert property (@(posedge clk) disable iff (rst)
    (step && core_res.event_code == EV_RAPID) |=> !core_st.tracking)
    else $error("tracking still set after rapid press");

  // a release poll leaves the contact open and tracking re-armed
  a_release_rearms: assert property (@(posedge clk) disable iff (rst)
    (step && s1_level) |=> (core_st.tracking && core_st.phase == PH_OPEN))
    else $error("release did not re-arm tracking");

  // input side only stalls when both registers are full and the result is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !poll.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("poll stalled without a full, stalled pipeline");

endmodule

`default_nettype wire

// ===== tb/button_debounce_multi_press_test.sv =====
`timescale 1ns / 100ps
// button_debounce_multi_press_test: self-checking bench for the debounce / multi-press block.
// Predicts every result from its own copy of the press state, checks results in order.
// Depends on dmp_pkg, dmp_in_if, dmp_out_if and the button_debounce_multi_press RTL.

module button_debounce_multi_press_test;
  import dmp_pkg::*;

  typedef struct {
    logic        level;
    logic [31:0] now;
  } poll_item_t;

  localparam int LONG_STALL = 300;   // hold-off counter load for the one long result-side stall

  logic clk = 1'b0;
  logic rst;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  dmp_in_if  poll_ch ();
  dmp_out_if res_ch ();

  button_debounce_multi_press uut (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll_ch.sink),
    .result    (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Stimulus and checking stores
  poll_item_t polls_to_send[$];
  res_t       pending_events[$];
  int         mismatch_cnt = 0;

  // Traffic shaping, set by the sequencer, read by driver and receiver
  int   src_idle_pct;
  int   sink_idle_pct;
  logic long_stall_req;
  logic long_stall_done;
  int   stall_left;

  // ---------------------------------------------------------------------------
  // Press tracker: bench-side copy of the block's state and configuration
  // ---------------------------------------------------------------------------
  cfg_t        cur_cfg;
  phase_t      pr_phase;
  logic [31:0] pr_deadline;
  logic [31:0] pr_first;      // zero means no press yet
  logic [31:0] pr_last;       // zero means no second press yet
  logic [7:0]  pr_count;
  logic        pr_tracking;

  function automatic void tracker_reset();
    cur_cfg.debounce_ms  = DEBOUNCE_RST;
    cur_cfg.gap_limit_ms = GAP_RST;
    cur_cfg.window_ms    = WINDOW_RST;
    cur_cfg.rapid_count  = RAPID_RST;
    pr_phase    = PH_OPEN;
    pr_deadline = '0;
    pr_first    = '0;
    pr_last     = '0;
    pr_count    = '0;
    pr_tracking = 1'b1;
  endfunction

  function automatic void drop_series();
    pr_first = '0;
    pr_last  = '0;
    pr_count = '0;
  endfunction

  function automatic logic [31:0] since_first(input logic [31:0] now);
    return (pr_first == 0) ? 32'd0 : now - pr_first;
  endfunction

  // Falls back to the first press time while only one press is on record
  function automatic logic [31:0] since_last(input logic [31:0] now);
    return (pr_last == 0) ? since_first(now) : now - pr_last;
  endfunction

  function automatic res_t debounce_step(input logic level, input logic [31:0] now);
    res_t        r;
    event_t      code;
    logic [31:0] past_deadline;
    if (level) begin
      // release: may close a series that ran out of gap or window
      pr_phase = PH_OPEN;
      code = EV_NONE;
      if (pr_tracking && (since_last(now) > cur_cfg.gap_limit_ms ||
                          since_first(now) > cur_cfg.window_ms)) begin
        code = EV_PRESS;
        drop_series();
      end
      pr_tracking = 1'b1;
    end else begin
      if (pr_phase == PH_OPEN) begin
        pr_phase    = PH_CONTACT;
        pr_deadline = now + cur_cfg.debounce_ms;
      end else if (pr_phase == PH_CONTACT) begin
        // wrap-safe: reached when the difference is non-negative
        past_deadline = now - pr_deadline;
        if (!past_deadline[31]) begin
          if (pr_count == 0) pr_first = now;
          else pr_last = now;
          if (pr_count != 8'hFF) pr_count = pr_count + 8'd1;
          pr_phase = PH_PRESSING;
        end
      end
      code = (pr_phase == PH_CONTACT) ? EV_CONTACT : EV_PRESSING;
      if (pr_tracking) begin
        if (pr_count == cur_cfg.rapid_count && since_first(now) <= cur_cfg.window_ms) begin
          code = EV_RAPID;
          drop_series();
          pr_tracking = 1'b0;
        end else if (since_last(now) > cur_cfg.gap_limit_ms ||
                     since_first(now) > cur_cfg.window_ms) begin
          code = EV_PRESS;
          drop_series();
          pr_tracking = 1'b0;
        end
      end
    end
    r.event_code = code;
    r.busy_res   = pr_tracking && !(pr_phase == PH_OPEN && pr_count == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Poll driver: one NBA per signal per edge, prediction at each transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : poll_driver
    poll_item_t nxt;
    if (rst) begin
      poll_ch.valid        <= 1'b0;
      poll_ch.button_level <= 1'b1;
      poll_ch.now_ms       <= '0;
    end else begin
      if (poll_ch.valid && poll_ch.ready)
        pending_events.push_back(debounce_step(poll_ch.button_level, poll_ch.now_ms));
      if (!poll_ch.valid || poll_ch.ready) begin
        if (polls_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = polls_to_send.pop_front();
          poll_ch.valid        <= 1'b1;
          poll_ch.button_level <= nxt.level;
          poll_ch.now_ms       <= nxt.now;
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_ready_gen
    if (rst) begin
      res_ch.ready    <= 1'b0;
      stall_left      <= 0;
      long_stall_done <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (long_stall_req && !long_stall_done) begin
      // block fills up behind this, poll.ready must drop
      res_ch.ready    <= 1'b0;
      stall_left      <= LONG_STALL;
      long_stall_done <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: in-order compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_events.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected result code=%0d busy=%0b", $realtime,
                   res_ch.event_code, res_ch.busy_res);
      end else begin
        want = pending_events.pop_front();
        if (res_ch.event_code !== want.event_code || res_ch.busy_res !== want.busy_res) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result mismatch: expected code=%0d busy=%0b, got code=%0d busy=%0b",
                     $realtime, want.event_code, want.busy_res,
                     res_ch.event_code, res_ch.busy_res);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_poll(input logic level, input logic [31:0] now);
    poll_item_t p;
    p.level = level;
    p.now   = now;
    polls_to_send.push_back(p);
  endtask

  // Span relative to a limit: below, right at the edge, or past it
  function automatic logic [31:0] pick_span(input logic [15:0] lim);
    logic [31:0] l;
    l = {16'd0, lim};
    case ($urandom_range(2))
      0:       return $urandom_range(l);
      1:       return (l == 0) ? $urandom_range(1) : l - 1 + $urandom_range(2);
      default: return l + 1 + $urandom_range(l + 1);
    endcase
  endfunction

  // Mostly complete presses (with bounce, held polls, release and a gap tuned
  // against the gap limit), some open/closed noise and a few time jumps.
  task automatic add_random_polls(input int n_items);
    logic [31:0] t;
    logic [31:0] t_contact;
    int          stop;
    int          kind;
    int          k;
    t    = $urandom();
    stop = polls_to_send.size() + n_items;
    while (polls_to_send.size() < stop) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        if ($urandom_range(3) == 0) begin
          // contact bounce, released before it settles
          push_poll(1'b0, t);
          t += $urandom_range(cur_cfg.debounce_ms / 2);
          push_poll(1'b1, t);
          t += $urandom_range(3);
        end
        t_contact = t;
        push_poll(1'b0, t);
        for (k = $urandom_range(2); k > 0; k--) begin
          t = t_contact + $urandom_range(cur_cfg.debounce_ms);
          push_poll(1'b0, t);
        end
        t = t_contact + cur_cfg.debounce_ms +
            (($urandom_range(4) == 0) ? $urandom_range(100) : $urandom_range(1));
        push_poll(1'b0, t);
        for (k = $urandom_range(3); k > 0; k--) begin
          t += $urandom_range(cur_cfg.gap_limit_ms / 2 + 2);
          push_poll(1'b0, t);
        end
        t += $urandom_range(5);
        push_poll(1'b1, t);
        t += pick_span(cur_cfg.gap_limit_ms);
      end else if (kind < 92) begin
        push_poll(1'($urandom_range(1)), t);
        t += $urandom_range(cur_cfg.window_ms + 2);
      end else begin
        // time jump, sometimes to just short of the wrap
        t = ($urandom_range(1) == 0) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(2000);
        push_poll(1'($urandom_range(1)), t);
      end
    end
  endtask

  // Quick presses with zero debounce: drives the press counter into saturation
  task automatic add_press_run(input int n_press);
    logic [31:0] t;
    int          i;
    t = $urandom_range(32'h7FFF_FFFF, 1000);
    push_poll(1'b1, t);
    t += 70000;                  // clears whatever series is left over
    push_poll(1'b1, t);
    for (i = 0; i < n_press; i++) begin
      t += $urandom_range(2);
      push_poll(1'b0, t);        // contact
      t += $urandom_range(2);
      push_poll(1'b0, t);        // press counted
      t += $urandom_range(2);
      push_poll(1'b1, t);        // release
    end
  endtask

  // Writes all four registers back to back; only called while idle
  task automatic set_config(input logic [15:0] dbn, input logic [15:0] gap,
                            input logic [15:0] win, input logic [7:0] rapid);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= dbn;
    @(posedge clk);
    cfg_index <= CFG_GAP;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    cfg_index <= CFG_RAPID;
    cfg_data  <= {8'd0, rapid};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg.debounce_ms  = dbn;
    cur_cfg.gap_limit_ms = gap;
    cur_cfg.window_ms    = win;
    cur_cfg.rapid_count  = rapid;
  endtask

  // Idle = nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (polls_to_send.size() != 0 || poll_ch.valid || pending_events.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int   i;
    logic [15:0] g;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_DEBOUNCE;
    cfg_data             = '0;
    src_idle_pct         = 19;
    sink_idle_pct        = 55;
    long_stall_req       = 1'b0;
    tracker_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values (50 / 500 / 1500 / 3)
    push_poll(1'b1, 32'd100);                                  // idle open
    push_poll(1'b0, 32'd110);  push_poll(1'b1, 32'd120);       // bounce
    push_poll(1'b0, 32'd130);  push_poll(1'b0, 32'd150);       // before deadline
    push_poll(1'b0, 32'd180);  push_poll(1'b0, 32'd300);       // press, then held
    push_poll(1'b1, 32'd320);
    push_poll(1'b0, 32'd400);  push_poll(1'b0, 32'd460);  push_poll(1'b1, 32'd480);
    push_poll(1'b0, 32'd600);  push_poll(1'b0, 32'd650);       // third press: rapid
    push_poll(1'b1, 32'd700);                                  // release, not tracking
    push_poll(1'b0, 32'd1000); push_poll(1'b0, 32'd1060); push_poll(1'b1, 32'd1100);
    push_poll(1'b1, 32'd1700);                                 // gap exceeded: press
    push_poll(1'b0, 32'hFFFF_FFC0); push_poll(1'b0, 32'd0);    // press stamped at zero
    push_poll(1'b1, 32'd10);
    push_poll(1'b0, 32'd20);   push_poll(1'b0, 32'd80);   push_poll(1'b1, 32'd90);
    push_poll(1'b0, 32'hFFFF_FFFF);                            // deadline wraps to 49
    push_poll(1'b0, 32'h8000_0040);                            // top bit set: not reached
    push_poll(1'b0, 32'h7FFF_FFFF);                            // reached
    push_poll(1'b1, 32'h8000_0004);
    wait_idle();

    // Low extremes, with one long result-side hold-off
    set_config(16'd0, 16'd0, 16'd0, 8'd1);
    add_random_polls(150);
    long_stall_req = 1'b1;
    wait_idle();

    // High extremes
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_random_polls(120);
    wait_idle();

    // Receiver busier than sender from here
    src_idle_pct  = 55;
    sink_idle_pct = 19;

    // Rapid count of zero: counter runs up to its limit
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 8'd0);
    add_press_run(260);
    wait_idle();

    g = 16'($urandom_range(600, 10));
    set_config(16'($urandom_range(80)), g, 16'($urandom_range(2000)),
               8'($urandom_range(5, 1)));
    add_random_polls(100);
    wait_idle();

    // No idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (i = 0; i < 3; i++) begin
      if (i == 2) begin
        set_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                   16'($urandom_range(16'hFFFF)), 8'($urandom_range(255, 1)));
      end else begin
        g = 16'($urandom_range(600, 10));
        set_config(16'($urandom_range(80)), g, 16'($urandom_range(2000, g)),
                   8'($urandom_range(5, 2)));
      end
      add_random_polls(110);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS button_debounce_multi_press");
    end else begin
      $display("FAIL button_debounce_multi_press");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("FAIL button_debounce_multi_press");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dmp_pkg.sv
hw/rtl/dmp_in_if.sv
hw/rtl/dmp_out_if.sv
hw/rtl/dmp_cfg.sv
hw/rtl/dmp_core.sv
hw/rtl/button_debounce_multi_press.sv
tb/button_debounce_multi_press_test.sv
